>>> hdl/ljpu_pkg.sv
`timescale 1ns / 1ps
package ljpu_pkg;

    localparam int MAX_BEADS_DEF = 1024;
    localparam int IDX_W         = 10;
    localparam int POS_W         = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int DIV_STEPS     = 32;

    // item kinds
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_PAIR = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_COINC = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 3'd4;

    localparam logic [31:0] REP_RST   = 32'd65536;
    localparam logic [31:0] ATT_RST   = 32'd65536;
    localparam logic [15:0] STEP_RST  = 16'd655;
    localparam logic        FIXED_RST = 1'b1;
    localparam logic [9:0]  LAST_RST  = 10'd1023;

    localparam logic signed [48:0] FORCE_CAP = 49'sd19660800;
    localparam logic signed [48:0] FORCE_MIN = -49'sd2147483648;
    localparam logic [63:0]        R2_SAT_LIM = 64'd65536;
    localparam logic [63:0]        DIV_INIT   = 64'd65536;

    typedef struct packed {
        logic [31:0] rep;
        logic [31:0] att;
        logic [15:0] step;
        logic        fixed;
        logic [9:0]  last;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NOP, OP_CAPTURE, OP_DEC, OP_RDLAT, OP_RDB, OP_DIFF, OP_SQ, OP_SQE,
        OP_CHK, OP_DIV, OP_DIVE, OP_PMUL, OP_PSTORE, OP_FORCE, OP_FDM, OP_FDS,
        OP_STM, OP_UPD, OP_WRI, OP_WRJ, OP_RESULT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       ok;
        logic       r2_zero;
        logic       r2_small;
        logic       out_free;
    } t_stat;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_RDW, S_RDB, S_DIFF, S_SQ, S_SQE, S_CHK, S_DIV, S_DIVE,
        S_PM, S_PS, S_FORCE, S_FDM, S_FDS, S_STM, S_UPD, S_WRI, S_WRJ, S_DONE
    } t_state;

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] sat_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) begin
            return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return d[31:0];
    endfunction

    // (a*b)>>16 saturated to 32 bits
    function automatic logic [31:0] qsat(input logic [63:0] p);
        if (p[63:48] != 16'd0) begin
            return 32'hFFFF_FFFF;
        end
        return p[47:16];
    endfunction

endpackage

>>> hdl/lennard_jones_pair_position_update.sv
`timescale 1ns / 1ps
// Lennard-Jones 12-6 pair force with bead position update.
// Input stream s_axis: tuser carries the item kind (load, pair, read); tdata
// carries bead indexes and a position to load. Output stream m_axis: tuser
// carries the status, tdata the force scalar and a read position. The cfg
// channel writes rep_coeff, att_coeff, step_size, the end-pinning flag and
// last_index by index; it is always ready. The user writes it only while the
// block is idle; the block itself does not enforce this. One item is worked
// at a time: the next input word is accepted once the last result is in the
// output register. A pair with r^2 <= 2^-16 (inverse saturates) skips the
// divider; a coincident pair skips the force and the update.
// The 32 steps of the restoring divider for 1/r^2 and the single shared 33x33
// multiplier that runs r^2, the power chain and f*d do the pair work; a
// separate 48x17 multiplier applies the step.
// The result sits in an output register, so the next word is accepted while
// it waits; a stalled receiver holds a finished result in the controller's
// done state until the register frees. Reset clears control state and loads
// the register defaults; the position memory is not cleared.
module lennard_jones_pair_position_update #(
    parameter int MAX_BEADS = ljpu_pkg::MAX_BEADS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // index_a, index_b, pos_x, pos_y, pos_z
    input  logic [119:0]                   s_axis_tdata,
    input  logic [1:0]                     s_axis_tuser,  // func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // force_scalar, read_x, read_y, read_z
    output logic [127:0]                   m_axis_tdata,
    output logic [1:0]                     m_axis_tuser,  // status
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ljpu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import ljpu_pkg::*;

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic [31:0] force_s, rx, ry, rz;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rep   <= REP_RST;
            r_cfg.att   <= ATT_RST;
            r_cfg.step  <= STEP_RST;
            r_cfg.fixed <= FIXED_RST;
            r_cfg.last  <= LAST_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REP:   r_cfg.rep   <= i_cfg_data;
                CFG_ATT:   r_cfg.att   <= i_cfg_data;
                CFG_STEP:  r_cfg.step  <= i_cfg_data[15:0];
                CFG_FIXED: r_cfg.fixed <= i_cfg_data[0];
                CFG_LAST:  r_cfg.last  <= i_cfg_data[9:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    ljpu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ljpu_dp #(
        .MAX_BEADS (MAX_BEADS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cfg     (r_cfg),
        .i_func    (s_axis_tuser),
        .i_index_a (s_axis_tdata[9:0]),
        .i_index_b (s_axis_tdata[19:10]),
        .i_pos_x   (s_axis_tdata[51:20]),
        .i_pos_y   (s_axis_tdata[83:52]),
        .i_pos_z   (s_axis_tdata[115:84]),
        .o_stat    (stat),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_status  (m_axis_tuser),
        .o_force   (force_s),
        .o_read_x  (rx),
        .o_read_y  (ry),
        .o_read_z  (rz)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tdata  = {rz, ry, rx, force_s};

endmodule

>>> hdl/ljpu_ctrl.sv
`timescale 1ns / 1ps
module ljpu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ljpu_pkg::t_stat i_stat,
    output ljpu_pkg::t_cmd  o_cmd
);
    import ljpu_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NOP;
        o_cmd.idx  = r_cnt[2:0];
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.op = OP_DEC;
                case (i_stat.func)
                    FUNC_READ: n_state = i_stat.ok ? S_RDW : S_DONE;
                    FUNC_PAIR: n_state = i_stat.ok ? S_RDB : S_DONE;
                    default:   n_state = S_DONE;
                endcase
            end
            S_RDW: begin
                o_cmd.op = OP_RDLAT;
                n_state  = S_DONE;
            end
            S_RDB: begin
                o_cmd.op = OP_RDB;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_cnt    = 5'd0;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd2) begin
                    n_state = S_SQE;
                end
            end
            S_SQE: begin
                o_cmd.op = OP_SQE;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.op = OP_CHK;
                n_cnt    = 5'd0;
                if (i_stat.r2_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.r2_small) begin
                    n_state = S_DIVE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = S_DIVE;
                end
            end
            S_DIVE: begin
                o_cmd.op = OP_DIVE;
                n_cnt    = 5'd0;
                n_state  = S_PM;
            end
            S_PM: begin
                o_cmd.op = OP_PMUL;
                n_state  = S_PS;
            end
            S_PS: begin
                o_cmd.op = OP_PSTORE;
                if (r_cnt == 5'd5) begin
                    n_cnt   = 5'd0;
                    n_state = S_FORCE;
                end else begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_PM;
                end
            end
            S_FORCE: begin
                o_cmd.op = OP_FORCE;
                n_cnt    = 5'd0;
                n_state  = S_FDM;
            end
            S_FDM: begin
                o_cmd.op = OP_FDM;
                n_state  = S_FDS;
            end
            S_FDS: begin
                o_cmd.op = OP_FDS;
                n_state  = S_STM;
            end
            S_STM: begin
                o_cmd.op = OP_STM;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.op = OP_UPD;
                if (r_cnt == 5'd2) begin
                    n_state = S_WRI;
                end else begin
                    n_cnt   = r_cnt + 5'd1;
                    n_state = S_FDM;
                end
            end
            S_WRI: begin
                o_cmd.op = OP_WRI;
                n_state  = S_WRJ;
            end
            S_WRJ: begin
                o_cmd.op = OP_WRJ;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> hdl/ljpu_dp.sv
`timescale 1ns / 1ps
module ljpu_dp #(
    parameter int MAX_BEADS = ljpu_pkg::MAX_BEADS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ljpu_pkg::t_cmd            i_cmd,
    input  ljpu_pkg::t_cfg            i_cfg,
    input  logic [1:0]                i_func,
    input  logic [ljpu_pkg::IDX_W-1:0] i_index_a,
    input  logic [ljpu_pkg::IDX_W-1:0] i_index_b,
    input  logic [ljpu_pkg::POS_W-1:0] i_pos_x,
    input  logic [ljpu_pkg::POS_W-1:0] i_pos_y,
    input  logic [ljpu_pkg::POS_W-1:0] i_pos_z,
    output ljpu_pkg::t_stat           o_stat,
    input  logic                      i_m_ready,
    output logic                      o_m_valid,
    output logic [1:0]                o_status,
    output logic [31:0]               o_force,
    output logic [31:0]               o_read_x,
    output logic [31:0]               o_read_y,
    output logic [31:0]               o_read_z
);
    import ljpu_pkg::*;

    localparam int AW = $clog2(MAX_BEADS);

    logic [95:0]       r_mem [MAX_BEADS];
    logic [95:0]       r_rd;
    logic [1:0]        r_func;
    logic [IDX_W-1:0]  r_ia, r_ib;
    logic [31:0]       r_px, r_py, r_pz;
    logic [31:0]       r_pa [3];
    logic [31:0]       r_pb [3];
    logic [31:0]       r_d  [3];
    logic [1:0]        r_status;
    logic [31:0]       r_force;
    logic [63:0]       r_r2, r_rem, r_prod;
    logic [31:0]       r_q, r_i2, r_i4, r_i6, r_i8, r_i14;
    logic [47:0]       r_t12, r_t6;
    logic signed [47:0] r_fd;
    logic [63:0]       r_sprod;
    logic              r_m_valid;
    logic [1:0]        r_o_status;
    logic [31:0]       r_o_force, r_o_x, r_o_y, r_o_z;

    logic              a_in, b_in, pair_ok, ok, move_i, move_j, r2_small;
    logic [AW-1:0]     addr_a, addr_b, rd_addr, wr_addr;
    logic              wr_en;
    logic [95:0]       wr_data;
    logic [1:0]        k;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [64:0] step_p;
    logic [64:0]       nrem, rem_sub;
    logic              ge;
    logic signed [48:0] fdiff;
    logic [31:0]       fclamp;
    logic [47:0]       m;
    logic signed [49:0] sum_i, sum_j;

    assign k       = i_cmd.idx[1:0];
    assign a_in    = 32'(r_ia) < MAX_BEADS;
    assign b_in    = 32'(r_ib) < MAX_BEADS;
    assign pair_ok = (r_ia != '0) && (({1'b0, r_ia} + 11'd1) <= {1'b0, i_cfg.last}) &&
                     a_in && (r_ib <= i_cfg.last) && b_in;
    assign ok      = (r_func == FUNC_PAIR) ? pair_ok :
                     ((r_func == FUNC_LOAD) || (r_func == FUNC_READ)) ? a_in : 1'b0;
    assign move_i  = i_cfg.fixed;
    assign move_j  = !i_cfg.fixed || ((r_ib != '0) && (r_ib != i_cfg.last));
    assign r2_small = r_r2 <= R2_SAT_LIM;
    assign addr_a  = AW'(r_ia);
    assign addr_b  = AW'(r_ib);

    assign o_stat.func     = r_func;
    assign o_stat.ok       = ok;
    assign o_stat.r2_zero  = (r_r2 == 64'd0);
    assign o_stat.r2_small = r2_small;
    assign o_stat.out_free = !r_m_valid || i_m_ready;

    // bead memory: one write and one registered read per cycle
    assign rd_addr = (i_cmd.op == OP_RDB) ? addr_b : addr_a;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_a;
        wr_data = {r_pz, r_py, r_px};
        case (i_cmd.op)
            OP_DEC: wr_en = (r_func == FUNC_LOAD) && a_in;
            OP_WRI: begin
                wr_en   = move_i;
                wr_data = {r_pa[2], r_pa[1], r_pa[0]};
            end
            OP_WRJ: begin
                wr_en   = move_j;
                wr_addr = addr_b;
                wr_data = {r_pb[2], r_pb[1], r_pb[0]};
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_SQ: begin
                mul_a = {r_d[k][31], r_d[k]};
                mul_b = {r_d[k][31], r_d[k]};
            end
            OP_PMUL: begin
                case (i_cmd.idx)
                    3'd0: begin mul_a = {1'b0, r_i2};  mul_b = {1'b0, r_i2}; end
                    3'd1: begin mul_a = {1'b0, r_i4};  mul_b = {1'b0, r_i2}; end
                    3'd2: begin mul_a = {1'b0, r_i4};  mul_b = {1'b0, r_i4}; end
                    3'd3: begin mul_a = {1'b0, r_i8};  mul_b = {1'b0, r_i6}; end
                    3'd4: begin mul_a = {1'b0, i_cfg.rep}; mul_b = {1'b0, r_i14}; end
                    3'd5: begin mul_a = {1'b0, i_cfg.att}; mul_b = {1'b0, r_i8}; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            OP_FDM: begin
                mul_a = {r_force[31], r_force};
                mul_b = {r_d[k][31], r_d[k]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign step_p = r_fd * $signed({1'b0, i_cfg.step});

    // one restoring division step of 2^48 / r2
    assign nrem    = {r_rem, 1'b0};
    assign rem_sub = nrem - {1'b0, r_r2};
    assign ge      = nrem >= {1'b0, r_r2};

    assign fdiff = $signed({1'b0, r_t12}) - $signed({1'b0, r_t6});
    always_comb begin
        if (fdiff > FORCE_CAP) begin
            fclamp = FORCE_CAP[31:0];
        end else if (fdiff < FORCE_MIN) begin
            fclamp = 32'h8000_0000;
        end else begin
            fclamp = fdiff[31:0];
        end
    end

    assign m     = r_sprod[63:16];
    assign sum_i = $signed({{18{r_pa[k][31]}}, r_pa[k]}) + $signed({{2{m[47]}}, m});
    assign sum_j = $signed({{18{r_pb[k][31]}}, r_pb[k]}) - $signed({{2{m[47]}}, m});

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_func <= i_func;
                r_ia   <= i_index_a;
                r_ib   <= i_index_b;
                r_px   <= i_pos_x;
                r_py   <= i_pos_y;
                r_pz   <= i_pos_z;
            end
            OP_DEC: begin
                r_status <= ok ? ST_DONE : ST_RANGE;
                r_force  <= 32'd0;
                r_r2     <= 64'd0;
            end
            OP_RDLAT, OP_RDB: begin
                r_pa[0] <= r_rd[31:0];
                r_pa[1] <= r_rd[63:32];
                r_pa[2] <= r_rd[95:64];
            end
            OP_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_pb[i] <= r_rd[32*i +: 32];
                    r_d[i]  <= sat_diff(r_pa[i], r_rd[32*i +: 32]);
                end
            end
            OP_SQ: begin
                r_prod <= mul_p[63:0];
                if (k == 2'd1) begin
                    r_r2 <= r_prod;
                end else if (k == 2'd2) begin
                    r_r2 <= r_r2 + r_prod;
                end
            end
            OP_SQE: r_r2 <= r_r2 + r_prod;
            OP_CHK: begin
                if (r_r2 == 64'd0) begin
                    r_status <= ST_COINC;
                end
                r_rem <= DIV_INIT;
                r_q   <= 32'd0;
            end
            OP_DIV: begin
                r_rem <= ge ? rem_sub[63:0] : nrem[63:0];
                r_q   <= {r_q[30:0], ge};
            end
            OP_DIVE: r_i2 <= r2_small ? 32'hFFFF_FFFF : r_q;
            OP_PMUL, OP_FDM: r_prod <= mul_p[63:0];
            OP_PSTORE: begin
                case (i_cmd.idx)
                    3'd0: r_i4  <= qsat(r_prod);
                    3'd1: r_i6  <= qsat(r_prod);
                    3'd2: r_i8  <= qsat(r_prod);
                    3'd3: r_i14 <= qsat(r_prod);
                    3'd4: r_t12 <= r_prod[63:16];
                    3'd5: r_t6  <= r_prod[63:16];
                    default: r_t6 <= r_t6;
                endcase
            end
            OP_FORCE: r_force <= fclamp;
            OP_FDS:   r_fd <= $signed(r_prod[63:16]);
            OP_STM:   r_sprod <= step_p[63:0];
            OP_UPD: begin
                r_pa[k] <= sat32(sum_i);
                r_pb[k] <= sat32(sum_j);
            end
            OP_RESULT: begin
                r_o_status <= r_status;
                r_o_force  <= r_force;
                if ((r_func == FUNC_READ) && (r_status == ST_DONE)) begin
                    r_o_x <= r_pa[0];
                    r_o_y <= r_pa[1];
                    r_o_z <= r_pa[2];
                end else begin
                    r_o_x <= 32'd0;
                    r_o_y <= 32'd0;
                    r_o_z <= 32'd0;
                end
            end
            default: r_func <= r_func;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.op == OP_RESULT) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_status  = r_o_status;
    assign o_force   = r_o_force;
    assign o_read_x  = r_o_x;
    assign o_read_y  = r_o_y;
    assign o_read_z  = r_o_z;

endmodule

>>> hdl/ljpu_chk.sv
`timescale 1ns / 1ps
module ljpu_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    import ljpu_pkg::*;

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word accepted while one is in work");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    a_skip_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_DONE) |-> m_axis_tdata == 128'd0)
        else $error("skipped item carries nonzero data");

endmodule

bind lennard_jones_pair_position_update ljpu_chk u_ljpu_chk (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ljpu_pkg::*;

    localparam int NUM_ITEMS = 1300;
    localparam int WATCHDOG  = 20000;
    localparam int SETTLE    = 120;

    typedef struct {
        logic [1:0]  func;
        logic [9:0]  idx_a;
        logic [9:0]  idx_b;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } bead_cmd_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] force_q;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
    } bead_resp_t;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [119:0]  s_axis_tdata;
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [127:0]  m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]   i_cfg_data;

    lennard_jones_pair_position_update i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic signed [31:0] bead_pos [MAX_BEADS_DEF][3];
    logic [31:0] rep_c, att_c;
    logic [15:0] step_c;
    logic        fixed_c;
    logic [9:0]  last_c;

    // generator bookkeeping
    bit          loaded [MAX_BEADS_DEF];
    logic [9:0]  gen_last;

    bead_cmd_t  pending_cmds [$];
    bead_resp_t expected_resps [$];

    int  sent_cnt, resp_cnt, pair_cnt, coinc_cnt, range_cnt, err_cnt;
    int  idle_cnt;
    bit  word_taken;
    int  send_gap_pct, recv_stall_pct;

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = (a * b) >> 16;
        return (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
    endfunction

    // apply one word to the bead memory and return the answer it earns
    function automatic bead_resp_t lj_update(input bead_cmd_t c);
        bead_resp_t r;
        longint d [3];
        logic [63:0] r2, i2, i4, i6, i8, i14, t12, t6;
        longint f, fd, mv;
        bit move_i, move_j;
        r = '{ST_DONE, 32'd0, 32'd0, 32'd0, 32'd0};
        case (c.func)
            FUNC_LOAD: begin
                bead_pos[c.idx_a][0] = c.px;
                bead_pos[c.idx_a][1] = c.py;
                bead_pos[c.idx_a][2] = c.pz;
            end
            FUNC_READ: begin
                r.rx = bead_pos[c.idx_a][0];
                r.ry = bead_pos[c.idx_a][1];
                r.rz = bead_pos[c.idx_a][2];
            end
            FUNC_PAIR: begin
                if (c.idx_a < 1 || c.idx_a + 11'd1 > last_c || c.idx_b > last_c) begin
                    r.status = ST_RANGE;
                end else begin
                    r2 = 64'd0;
                    for (int k = 0; k < 3; k++) begin
                        d[k] = clip32(longint'(bead_pos[c.idx_a][k]) -
                                      longint'(bead_pos[c.idx_b][k]));
                        r2 += 64'(d[k] * d[k]);
                    end
                    if (r2 == 64'd0) begin
                        r.status = ST_COINC;
                    end else begin
                        i2 = (64'd1 << 48) / r2;
                        if (i2 > 64'hFFFF_FFFF) i2 = 64'hFFFF_FFFF;
                        i4  = qmul(i2, i2);
                        i6  = qmul(i4, i2);
                        i8  = qmul(i4, i4);
                        i14 = qmul(i8, i6);
                        t12 = ({32'd0, rep_c} * i14) >> 16;
                        t6  = ({32'd0, att_c} * i8) >> 16;
                        f = longint'(t12) - longint'(t6);
                        if (f > 64'sd19660800) f = 64'sd19660800;
                        if (f < -64'sd2147483648) f = -64'sd2147483648;
                        r.force_q = f[31:0];
                        move_i = fixed_c;
                        move_j = fixed_c ? (c.idx_b != 0 && c.idx_b != last_c) : 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            fd = (f * d[k]) >>> 16;
                            mv = (fd * longint'({48'd0, step_c})) >>> 16;
                            if (move_i)
                                bead_pos[c.idx_a][k] =
                                    clip32(longint'(bead_pos[c.idx_a][k]) + mv);
                            if (move_j)
                                bead_pos[c.idx_b][k] =
                                    clip32(longint'(bead_pos[c.idx_b][k]) - mv);
                        end
                    end
                end
            end
            default: r.status = ST_RANGE;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 6 * 65536) - 3 * 65536;
        return $urandom;
    endfunction

    task automatic push_cmd(input logic [1:0] f, input logic [9:0] a, input logic [9:0] b,
                            input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        bead_cmd_t c;
        c = '{f, a, b, x, y, z};
        if (f == FUNC_LOAD) loaded[a] = 1'b1;
        pending_cmds.push_back(c);
    endtask

    // load a bead first if it was never written, so nothing unwritten is read
    task automatic make_loaded(input logic [9:0] a);
        if (!loaded[a])
            push_cmd(FUNC_LOAD, a, 10'($urandom), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic push_random();
        int sel;
        logic [9:0] a, b;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            a = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, gen_last));
            push_cmd(FUNC_LOAD, a, 10'($urandom), rand_coord(), rand_coord(), rand_coord());
        end else if (sel < 75) begin
            if ($urandom_range(0, 9) == 0) begin
                // out of range pair: no bead is read
                a = 10'($urandom);
                b = 10'($urandom);
                if (a >= 1 && a + 11'd1 <= gen_last && b <= gen_last) a = 10'd0;
            end else begin
                a = 10'($urandom_range(1, gen_last - 1));
                b = ($urandom_range(0, 9) == 0) ? a : 10'($urandom_range(0, gen_last));
                make_loaded(a);
                make_loaded(b);
            end
            push_cmd(FUNC_PAIR, a, b, $urandom, $urandom, $urandom);
        end else if (sel < 95) begin
            a = 10'($urandom);
            make_loaded(a);
            push_cmd(FUNC_READ, a, 10'($urandom), $urandom, $urandom, $urandom);
        end else begin
            push_cmd(2'd3, 10'($urandom), 10'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_REP:   rep_c   = val;
            CFG_ATT:   att_c   = val;
            CFG_STEP:  step_c  = val[15:0];
            CFG_FIXED: fixed_c = val[0];
            CFG_LAST:  last_c  = val[9:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] rep, input logic [31:0] att,
                              input logic [15:0] stp, input logic fx, input logic [9:0] lst);
        cfg_write(CFG_REP, rep);
        cfg_write(CFG_ATT, att);
        cfg_write(CFG_STEP, {16'd0, stp});
        cfg_write(CFG_FIXED, {31'd0, fx});
        cfg_write(CFG_LAST, {22'd0, lst});
        gen_last = lst;
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && expected_resps.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // driver: advance to the next word once the current one is taken
    always @(negedge i_clk) begin
        if (sent_cnt < NUM_ITEMS / 3) begin
            send_gap_pct = 11;
            recv_stall_pct = 65;
        end else if (sent_cnt < 2 * NUM_ITEMS / 3) begin
            send_gap_pct = 65;
            recv_stall_pct = 11;
        end else begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
        end
        if (i_rst_n) begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!s_axis_tvalid || word_taken) begin
                word_taken = 1'b0;
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_cmds[0].func;
                    s_axis_tdata  <= {4'd0, pending_cmds[0].pz, pending_cmds[0].py,
                                      pending_cmds[0].px, pending_cmds[0].idx_b,
                                      pending_cmds[0].idx_a};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready && !word_taken) begin
            expected_resps.push_back(lj_update(pending_cmds[0]));
            if (pending_cmds[0].func == FUNC_PAIR) pair_cnt++;
            void'(pending_cmds.pop_front());
            word_taken = 1'b1;
            sent_cnt++;
        end
    end

    // monitor: compare every result word with the oldest prediction
    always @(posedge i_clk) begin
        bead_resp_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            resp_cnt++;
            if (m_axis_tuser == ST_COINC) coinc_cnt++;
            if (m_axis_tuser == ST_RANGE) range_cnt++;
            if (expected_resps.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result word: status %0d data %h",
                             m_axis_tuser, m_axis_tdata);
            end else begin
                e = expected_resps.pop_front();
                if (m_axis_tuser != e.status || m_axis_tdata[31:0] != e.force_q ||
                    m_axis_tdata[63:32] != e.rx || m_axis_tdata[95:64] != e.ry ||
                    m_axis_tdata[127:96] != e.rz) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"result %0d: expected st %0d f %h xyz %h %h %h,",
                                  " got st %0d f %h xyz %h %h %h"},
                                 resp_cnt, e.status, e.force_q, e.rx, e.ry, e.rz,
                                 m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tdata[95:64], m_axis_tdata[127:96]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("watchdog expired with %0d words pending", expected_resps.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        word_taken = 1'b0;
        sent_cnt = 0; resp_cnt = 0; pair_cnt = 0; coinc_cnt = 0; range_cnt = 0;
        err_cnt = 0; idle_cnt = 0;
        rep_c = REP_RST; att_c = ATT_RST; step_c = STEP_RST;
        fixed_c = FIXED_RST; last_c = LAST_RST; gen_last = LAST_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, saturating difference, coincident and range cases
        push_cmd(FUNC_LOAD, 10'd0, 10'h3FF, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_LOAD, 10'd1, 10'd0, 32'h0001_0000, 32'h0, 32'h0);
        push_cmd(FUNC_LOAD, 10'd2, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_cmd(FUNC_LOAD, 10'd3, 10'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_cmd(FUNC_LOAD, 10'd1022, 10'd0, 32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000);
        push_cmd(FUNC_LOAD, 10'd1023, 10'd0, 32'h0, 32'h0000_0100, 32'h0);
        push_cmd(FUNC_READ, 10'd1023, 10'd0, 32'hFFFF_FFFF, 32'h0, 32'h0);
        push_cmd(FUNC_READ, 10'd2, 10'd0, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_PAIR, 10'd1, 10'd1, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_PAIR, 10'd1, 10'd0, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_PAIR, 10'd0, 10'd1, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_PAIR, 10'd1022, 10'd1023, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_PAIR, 10'd1023, 10'd1, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_PAIR, 10'd2, 10'd3, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_PAIR, 10'd3, 10'd2, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_PAIR, 10'd1, 10'd1022, 32'h0, 32'h0, 32'h0);
        push_cmd(2'd3, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(FUNC_READ, 10'd1, 10'd0, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_READ, 10'd1022, 10'd0, 32'h0, 32'h0, 32'h0);
        push_cmd(FUNC_READ, 10'd3, 10'd0, 32'h0, 32'h0, 32'h0);
        repeat (200) push_random();
        drain();

        // strongest repulsion, full step, only bead j moves, shortest chain
        set_config(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 1'b0, 10'd2);
        repeat (100) push_random();
        drain();

        // pure attraction, zero step
        set_config(32'h0, 32'hFFFF_FFFF, 16'h0, 1'b1, 10'd1023);
        repeat (100) push_random();
        drain();

        set_config($urandom, $urandom, 16'($urandom), 1'($urandom),
                   10'($urandom_range(3, 1023)));
        repeat (170) push_random();
        drain();

        set_config(REP_RST, ATT_RST, STEP_RST, FIXED_RST, LAST_RST);
        repeat (170) push_random();
        drain();

        $display("sent %0d words, checked %0d results: %0d pairs, %0d coincident,",
                 sent_cnt, resp_cnt, pair_cnt, coinc_cnt);
        $display("%0d out of range, five register settings, %0d mismatches",
                 range_cnt, err_cnt);
        if (err_cnt == 0 && expected_resps.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
